FILE: design/svge_pkg.sv
// Shared constants, types and helpers of the state vector gate engine.
`default_nettype none
package svge_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int AMP_W      = FRAC_BITS + 2;
  localparam int ADDR_W     = MAX_QUBITS;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int QCNT_W     = 4;
  localparam int PROB_W     = 44;
  localparam int SQ_W       = 2 * AMP_W;
  localparam int SUM_W      = ADDR_W + SQ_W;
  localparam int ROOT_W     = (SUM_W + 1) / 2;
  localparam int SCALE_W    = 2 * FRAC_BITS + 1;
  localparam int PRD_W      = AMP_W + SCALE_W;
  localparam int MACC_W     = AMP_W + 6;
  localparam int CNT_W      = 6;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << FRAC_BITS;
  localparam logic signed [MACC_W-1:0] MACC_HI = MACC_W'((1 << (AMP_W - 1)) - 1);
  localparam logic signed [MACC_W-1:0] MACC_LO = -MACC_HI - MACC_W'(1);
  localparam logic [AMP_W-1:0] AMP_HI = {1'b0, {(AMP_W-1){1'b1}}};
  localparam logic [AMP_W-1:0] AMP_LO = {1'b1, {(AMP_W-1){1'b0}}};

  typedef logic signed [AMP_W-1:0] amp_t;

  typedef struct packed {
    amp_t re;
    amp_t im;
  } cplx_t;

  typedef enum logic [2:0] {
    MODE_RESET = 3'd0,
    MODE_READ  = 3'd1,
    MODE_WRMAT = 3'd2,
    MODE_GATE1 = 3'd3,
    MODE_GATE2 = 3'd4,
    MODE_PROB  = 3'd5,
    MODE_NORM  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_RANGE = 3'd1,
    STAT_SAME  = 3'd2,
    STAT_ZERO  = 3'd3,
    STAT_SAT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_AMP,
    OUT_PROB
  } outsel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] pb;
    logic              clr_wr;
    logic              mat_we;
    logic              sum_rd;
    logic              sum_inc;
    logic              acc_clr;
    logic              flags_clr;
    logic              ld_old;
    logic [1:0]        ld_idx;
    logic              mac_vld;
    logic [1:0]        mac_r;
    logic [1:0]        mac_j;
    logic              mac_first;
    logic              mac_last;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              div_first;
    logic              scl_vld;
    logic              out_load;
    outsel_t           out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic sat;
    logic prob_over;
    logic norm_zero;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] grp_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] pa,
                                                 input logic [ADDR_W-1:0] pb,
                                                 input logic [1:0]        r);
    grp_addr = base | (r[0] ? pa : '0) | (r[1] ? pb : '0);
  endfunction

endpackage
`default_nettype wire

FILE: design/svge_datapath.sv
// Datapath: amplitude store, gate matrix, multiply-accumulate, sum, root, divide, scale.
`default_nettype none
module svge_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  svge_pkg::dp_cmd_t              cmd,
  input  logic [1:0]                     mat_row,
  input  logic [1:0]                     mat_col,
  input  svge_pkg::amp_t                 entry_re,
  input  svge_pkg::amp_t                 entry_im,
  output svge_pkg::dp_stat_t             stat,
  output svge_pkg::amp_t                 amp_re,
  output svge_pkg::amp_t                 amp_im,
  output logic [svge_pkg::PROB_W-1:0]    probability
);
  import svge_pkg::*;

  function automatic logic [AMP_W-1:0] mag(input amp_t v);
    mag = v[AMP_W-1] ? AMP_W'(-v) : AMP_W'(v);
  endfunction

  // {saturated, value}
  function automatic logic [AMP_W:0] clip_amp(input logic signed [MACC_W-1:0] v);
    if (v > MACC_HI) clip_amp = {1'b1, AMP_HI};
    else if (v < MACC_LO) clip_amp = {1'b1, AMP_LO};
    else clip_amp = {1'b0, v[AMP_W-1:0]};
  endfunction

  function automatic logic [AMP_W:0] scale_fix(input logic [PRD_W-1:0] prod, input logic neg);
    logic [PRD_W-1:0] p;
    p = neg ? ((prod + PRD_W'((1 << FRAC_BITS) - 1)) >> FRAC_BITS) : (prod >> FRAC_BITS);
    if (neg) begin
      if (p > PRD_W'(1 << (AMP_W - 1))) scale_fix = {1'b1, AMP_LO};
      else scale_fix = {1'b0, AMP_W'(-p)};
    end else begin
      if (p > PRD_W'((1 << (AMP_W - 1)) - 1)) scale_fix = {1'b1, AMP_HI};
      else scale_fix = {1'b0, p[AMP_W-1:0]};
    end
  endfunction

  cplx_t amp_mem [DEPTH];
  cplx_t rd_q;
  cplx_t mat [16];
  cplx_t old [4];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cplx_t             mem_wdata;

  // gate multiply-accumulate
  logic signed [SQ_W-1:0]   p_rr, p_ii, p_ri, p_ir;
  logic                     mac_vld_q, mac_first_q, mac_last_q;
  logic [1:0]               mac_j_q;
  logic signed [MACC_W-1:0] macc_re, macc_im;
  logic signed [MACC_W-1:0] term_re, term_im, msum_re, msum_im;
  logic [AMP_W:0]           cl_re, cl_im;
  cplx_t                    mat_sel, old_sel;

  // sum of squares
  logic                     rd_vld_q, inc_q, sq_vld;
  logic [SQ_W-1:0]          sq_re, sq_im;
  logic [SUM_W-1:0]         acc;
  cplx_t                    amp_hold;
  logic [AMP_W-1:0]         mag_re, mag_im;

  // root and reciprocal
  logic [SUM_W-1:0]         rt_rem, rt_root, rt_bit;
  logic [SUM_W:0]           rt_trial;
  logic [ROOT_W-1:0]        norm;
  logic [ROOT_W-1:0]        drem;
  logic [ROOT_W:0]          dshift;
  logic [SCALE_W-1:0]       quo;

  // scaling
  logic                     scl_vld_q1, scl_vld_q2, neg_re, neg_im;
  logic [ADDR_W-1:0]        scl_addr_q1, scl_addr_q2;
  logic [PRD_W-1:0]         sp_re, sp_im;
  logic [AMP_W:0]           sc_re, sc_im;

  logic                     sat;

  assign mat_sel = mat[{cmd.mac_r, cmd.mac_j}];
  assign old_sel = old[cmd.mac_r];
  assign mag_re  = mag(rd_q.re);
  assign mag_im  = mag(rd_q.im);

  assign term_re = MACC_W'(p_rr >>> FRAC_BITS) - MACC_W'(p_ii >>> FRAC_BITS);
  assign term_im = MACC_W'(p_ri >>> FRAC_BITS) + MACC_W'(p_ir >>> FRAC_BITS);
  assign msum_re = (mac_first_q ? '0 : macc_re) + term_re;
  assign msum_im = (mac_first_q ? '0 : macc_im) + term_im;
  assign cl_re   = clip_amp(msum_re);
  assign cl_im   = clip_amp(msum_im);

  assign sc_re   = scale_fix(sp_re, neg_re);
  assign sc_im   = scale_fix(sp_im, neg_im);

  assign rt_trial = {1'b0, rt_root} + {1'b0, rt_bit};
  assign norm     = rt_root[ROOT_W-1:0];
  assign dshift   = {drem, cmd.div_first};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd.addr;
    mem_wdata = '0;
    priority if (cmd.clr_wr) begin
      mem_we = 1'b1;
      if (cmd.addr == '0) mem_wdata = '{re: AMP_ONE, im: '0};
    end else if (mac_vld_q && mac_last_q) begin
      mem_we    = 1'b1;
      mem_waddr = grp_addr(cmd.base, cmd.pa, cmd.pb, mac_j_q);
      mem_wdata = '{re: cl_re[AMP_W-1:0], im: cl_im[AMP_W-1:0]};
    end else if (scl_vld_q2) begin
      mem_we    = 1'b1;
      mem_waddr = scl_addr_q2;
      mem_wdata = '{re: sc_re[AMP_W-1:0], im: sc_im[AMP_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) amp_mem[mem_waddr] <= mem_wdata;
    rd_q <= amp_mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] <= '0;
    end else if (cmd.mat_we) begin
      mat[{mat_row, mat_col}] <= '{re: entry_re, im: entry_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      sq_vld     <= 1'b0;
      scl_vld_q1 <= 1'b0;
      scl_vld_q2 <= 1'b0;
      sat        <= 1'b0;
    end else begin
      mac_vld_q  <= cmd.mac_vld;
      rd_vld_q   <= cmd.sum_rd;
      sq_vld     <= rd_vld_q && inc_q;
      scl_vld_q1 <= cmd.scl_vld;
      scl_vld_q2 <= scl_vld_q1;
      if (cmd.flags_clr) sat <= 1'b0;
      else if ((mac_vld_q && mac_last_q && (cl_re[AMP_W] || cl_im[AMP_W])) ||
               (scl_vld_q2 && (sc_re[AMP_W] || sc_im[AMP_W]))) sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_old) old[cmd.ld_idx] <= rd_q;

    p_rr        <= $signed(old_sel.re) * $signed(mat_sel.re);
    p_ii        <= $signed(old_sel.im) * $signed(mat_sel.im);
    p_ri        <= $signed(old_sel.re) * $signed(mat_sel.im);
    p_ir        <= $signed(old_sel.im) * $signed(mat_sel.re);
    mac_j_q     <= cmd.mac_j;
    mac_first_q <= cmd.mac_first;
    mac_last_q  <= cmd.mac_last;
    if (mac_vld_q) begin
      macc_re <= msum_re;
      macc_im <= msum_im;
    end

    inc_q <= cmd.sum_inc;
    if (rd_vld_q) begin
      sq_re    <= mag_re * mag_re;
      sq_im    <= mag_im * mag_im;
      amp_hold <= rd_q;
    end
    if (cmd.acc_clr) acc <= '0;
    else if (sq_vld) acc <= acc + SUM_W'(sq_re) + SUM_W'(sq_im);

    if (cmd.sqrt_init) begin
      rt_rem  <= acc;
      rt_root <= '0;
      rt_bit  <= SUM_W'(1) << (2 * (ROOT_W - 1));
    end else if (cmd.sqrt_step) begin
      if ({1'b0, rt_rem} >= rt_trial) begin
        rt_rem  <= rt_rem - rt_trial[SUM_W-1:0];
        rt_root <= (rt_root >> 1) + rt_bit;
      end else begin
        rt_root <= rt_root >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end

    if (cmd.div_init) begin
      drem <= '0;
      quo  <= '0;
    end else if (cmd.div_step) begin
      if (dshift >= {1'b0, norm}) begin
        drem <= ROOT_W'(dshift - {1'b0, norm});
        quo  <= {quo[SCALE_W-2:0], 1'b1};
      end else begin
        drem <= dshift[ROOT_W-1:0];
        quo  <= {quo[SCALE_W-2:0], 1'b0};
      end
    end

    scl_addr_q1 <= cmd.addr;
    scl_addr_q2 <= scl_addr_q1;
    if (scl_vld_q1) begin
      sp_re  <= PRD_W'(mag_re) * PRD_W'(quo);
      sp_im  <= PRD_W'(mag_im) * PRD_W'(quo);
      neg_re <= rd_q.re[AMP_W-1];
      neg_im <= rd_q.im[AMP_W-1];
    end

    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        OUT_AMP: begin
          amp_re      <= amp_hold.re;
          amp_im      <= amp_hold.im;
          probability <= acc[PROB_W-1:0];
        end
        OUT_PROB: begin
          amp_re      <= '0;
          amp_im      <= '0;
          probability <= stat.prob_over ? '1 : acc[PROB_W-1:0];
        end
        default: begin
          amp_re      <= '0;
          amp_im      <= '0;
          probability <= '0;
        end
      endcase
    end
  end

  assign stat.sat       = sat;
  assign stat.prob_over = |acc[SUM_W-1:PROB_W];
  assign stat.norm_zero = (norm == '0);

endmodule
`default_nettype wire

FILE: design/svge_ctrl.sv
// Controller: command decode, sweep sequencing and result strobe.
`default_nettype none
module svge_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  output svge_pkg::status_t            status,
  input  logic [2:0]                   mode,
  input  logic [svge_pkg::ADDR_W-1:0]  amp_index,
  input  logic [3:0]                   qubit_a,
  input  logic [3:0]                   qubit_b,
  input  logic                         cfg_we,
  input  logic [svge_pkg::QCNT_W-1:0]  cfg_wdata,
  output svge_pkg::dp_cmd_t            cmd,
  input  svge_pkg::dp_stat_t           stat
);
  import svge_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_SUM, ST_DRAIN, ST_SQRT, ST_DIV,
    ST_SCALE, ST_SDRAIN, ST_GSCAN, ST_GLOAD, ST_GMAC, ST_FIN
  } state_t;

  state_t            state, acc_next;
  mode_t             op, mode_in;
  logic              boot, two_q;
  logic [ADDR_W-1:0] s, pa, pb, last, mask_a, mask_b;
  logic [CNT_W-1:0]  cnt, load_end, mac_end;
  logic [QCNT_W-1:0] qcount, n_eff;
  logic [ADDR_W:0]   span;
  logic              qa_bad, qb_bad, acc_fin;
  status_t           acc_code, fin_code;
  logic [1:0]        mac_r, mac_j, kmax;

  assign mode_in = mode_t'(mode);
  assign busy    = (state != ST_IDLE);

  always_comb begin
    priority if (qcount == '0) n_eff = QCNT_W'(1);
    else if (qcount > QCNT_W'(MAX_QUBITS)) n_eff = QCNT_W'(MAX_QUBITS);
    else n_eff = qcount;
  end

  assign span     = (ADDR_W + 1)'(1) << n_eff;
  assign last     = ADDR_W'(span - 1'b1);
  assign qa_bad   = (qubit_a >= n_eff);
  assign qb_bad   = (qubit_b >= n_eff);
  assign mask_a   = ADDR_W'(1) << qubit_a;
  assign mask_b   = ADDR_W'(1) << qubit_b;
  assign kmax     = two_q ? 2'd3 : 2'd1;
  assign load_end = CNT_W'(kmax) + CNT_W'(1);
  assign mac_end  = two_q ? CNT_W'(16) : CNT_W'(4);
  assign mac_r    = two_q ? cnt[1:0] : {1'b0, cnt[0]};
  assign mac_j    = two_q ? cnt[3:2] : {1'b0, cnt[1]};

  always_comb begin
    acc_fin  = 1'b0;
    acc_code = STAT_OK;
    acc_next = ST_IDLE;
    case (mode_in)
      MODE_RESET: acc_next = ST_CLEAR;
      MODE_READ: begin
        if (amp_index > last) begin
          acc_fin  = 1'b1;
          acc_code = STAT_RANGE;
        end else acc_next = ST_READ;
      end
      MODE_GATE1: begin
        if (qa_bad) begin
          acc_fin  = 1'b1;
          acc_code = STAT_RANGE;
        end else acc_next = ST_GSCAN;
      end
      MODE_GATE2: begin
        if (qa_bad || qb_bad) begin
          acc_fin  = 1'b1;
          acc_code = STAT_RANGE;
        end else if (qubit_a == qubit_b) begin
          acc_fin  = 1'b1;
          acc_code = STAT_SAME;
        end else acc_next = ST_GSCAN;
      end
      MODE_PROB: begin
        if (qa_bad) begin
          acc_fin  = 1'b1;
          acc_code = STAT_RANGE;
        end else acc_next = ST_SUM;
      end
      MODE_NORM: acc_next = ST_SUM;
      default: acc_fin = 1'b1;
    endcase
  end

  always_comb begin
    unique case (op)
      MODE_GATE1, MODE_GATE2: fin_code = stat.sat ? STAT_SAT : STAT_OK;
      MODE_PROB:              fin_code = stat.prob_over ? STAT_SAT : STAT_OK;
      MODE_NORM: begin
        if (stat.norm_zero) fin_code = STAT_ZERO;
        else fin_code = stat.sat ? STAT_SAT : STAT_OK;
      end
      default:                fin_code = STAT_OK;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.addr = s;
    cmd.base = s;
    cmd.pa   = pa;
    cmd.pb   = pb;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.mat_we    = (mode_in == MODE_WRMAT);
          cmd.acc_clr   = 1'b1;
          cmd.flags_clr = 1'b1;
          cmd.out_load  = acc_fin;
          cmd.out_sel   = OUT_NONE;
        end
      end
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_READ: begin
        cmd.sum_rd  = 1'b1;
        cmd.sum_inc = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_rd  = 1'b1;
        cmd.sum_inc = (op == MODE_NORM) || ((s & pa) != '0);
      end
      ST_SQRT: begin
        cmd.sqrt_init = (cnt == '0);
        cmd.sqrt_step = (cnt != '0);
      end
      ST_DIV: begin
        cmd.div_init  = (cnt == '0);
        cmd.div_step  = (cnt != '0);
        cmd.div_first = (cnt == CNT_W'(1));
      end
      ST_SCALE: cmd.scl_vld = 1'b1;
      ST_GLOAD: begin
        cmd.addr   = grp_addr(s, pa, pb, cnt[1:0]);
        cmd.ld_old = (cnt != '0);
        cmd.ld_idx = cnt[1:0] - 2'd1;
      end
      ST_GMAC: begin
        cmd.mac_vld   = (cnt < mac_end);
        cmd.mac_r     = mac_r;
        cmd.mac_j     = mac_j;
        cmd.mac_first = (mac_r == 2'd0);
        cmd.mac_last  = (mac_r == kmax);
      end
      ST_FIN: begin
        cmd.out_load = 1'b1;
        unique case (op)
          MODE_READ: cmd.out_sel = OUT_AMP;
          MODE_PROB: cmd.out_sel = OUT_PROB;
          default:   cmd.out_sel = OUT_NONE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      boot   <= 1'b1;
      op     <= MODE_RESET;
      two_q  <= 1'b0;
      s      <= '0;
      cnt    <= '0;
      pa     <= '0;
      pb     <= '0;
      qcount <= QCNT_W'(1);
      done   <= 1'b0;
      status <= STAT_OK;
    end else begin
      done <= 1'b0;
      if (cfg_we) qcount <= cfg_wdata;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op    <= mode_in;
            two_q <= (mode_in == MODE_GATE2);
            pa    <= mask_a;
            pb    <= (mode_in == MODE_GATE2) ? mask_b : '0;
            s     <= (mode_in == MODE_READ) ? amp_index : '0;
            cnt   <= '0;
            state <= acc_next;
            if (acc_fin) begin
              done   <= 1'b1;
              status <= acc_code;
            end
          end
        end
        ST_CLEAR: begin
          s <= s + 1'b1;
          if (s == '1) begin
            boot  <= 1'b0;
            state <= boot ? ST_IDLE : ST_FIN;
          end
        end
        ST_READ: state <= ST_DRAIN;
        ST_SUM: begin
          if (s == last) state <= ST_DRAIN;
          else s <= s + 1'b1;
        end
        ST_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(1)) begin
            cnt   <= '0;
            state <= (op == MODE_NORM) ? ST_SQRT : ST_FIN;
          end
        end
        ST_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_W)) begin
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == '0 && stat.norm_zero) state <= ST_FIN;
          else if (cnt == CNT_W'(SCALE_W)) begin
            cnt   <= '0;
            s     <= '0;
            state <= ST_SCALE;
          end else cnt <= cnt + 1'b1;
        end
        ST_SCALE: begin
          if (s == last) state <= ST_SDRAIN;
          else s <= s + 1'b1;
        end
        ST_SDRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(1)) begin
            cnt   <= '0;
            state <= ST_FIN;
          end
        end
        ST_GSCAN: begin
          if ((s & (pa | pb)) != '0) begin
            if (s == last) state <= ST_FIN;
            else s <= s + 1'b1;
          end else begin
            cnt   <= '0;
            state <= ST_GLOAD;
          end
        end
        ST_GLOAD: begin
          cnt <= cnt + 1'b1;
          if (cnt == load_end) begin
            cnt   <= '0;
            state <= ST_GMAC;
          end
        end
        ST_GMAC: begin
          cnt <= cnt + 1'b1;
          if (cnt == mac_end) begin
            cnt <= '0;
            if (s == last) state <= ST_FIN;
            else begin
              s     <= s + 1'b1;
              state <= ST_GSCAN;
            end
          end
        end
        ST_FIN: begin
          done   <= 1'b1;
          status <= fin_code;
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/state_vector_gate_engine.sv
// Top level of the state vector gate engine.
// A command is taken when start is high and busy is low; its single result beat
// appears in the cycle after start for a matrix write or a rejected command, or
// when the command completes, marked by done for one cycle, and cannot be held
// off. Commands run one at a time over an amplitude store with one read and one
// write port (1024 entries, one read and one write per cycle); sweeps cover the
// N = 2^qubit_count active states (qubit_count taken as 1 to 10). Reset state
// sweeps the whole store; a one-qubit gate scans, then per pair makes two loads
// and four complex multiply-accumulates (sixteen per quad for a two-qubit gate);
// normalize sums, takes a 23-step root and a 33-step reciprocal, then sweeps to
// scale. After reset the store is cleared with busy high; the qubit_count
// register may be written throughout.
`default_nettype none
module state_vector_gate_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  input  logic [2:0]                   mode,
  input  logic [9:0]                   amp_index,
  input  logic [1:0]                   mat_row,
  input  logic [1:0]                   mat_col,
  input  logic [3:0]                   qubit_a,
  input  logic [3:0]                   qubit_b,
  input  logic signed [17:0]           entry_re,
  input  logic signed [17:0]           entry_im,
  output logic signed [17:0]           amp_re,
  output logic signed [17:0]           amp_im,
  output logic [43:0]                  probability,
  output logic [2:0]                   status,
  input  logic                         cfg_we,
  input  logic [3:0]                   cfg_wdata
);
  import svge_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t dstat;
  status_t  ctrl_status;

  svge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (ctrl_status),
    .mode      (mode),
    .amp_index (amp_index),
    .qubit_a   (qubit_a),
    .qubit_b   (qubit_b),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (dstat)
  );

  svge_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mat_row     (mat_row),
    .mat_col     (mat_col),
    .entry_re    (entry_re),
    .entry_im    (entry_im),
    .stat        (dstat),
    .amp_re      (amp_re),
    .amp_im      (amp_im),
    .probability (probability)
  );

  assign status = ctrl_status;

endmodule
`default_nettype wire
